FILE: rtl/core/flr_pkg.sv
// flr_pkg: shared types, codes and constants of the framed link receiver
// used by every module under rtl/core but flr_fifo; depends on nothing
package flr_pkg;

  localparam int PAYLOAD_BYTES = 4;
  localparam int CMD_DEPTH     = 2;
  localparam int RES_DEPTH     = 2;
  localparam int TICK_W        = 16;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 16;

  localparam logic [7:0] BYTE_CR = 8'd13;
  localparam logic [7:0] BYTE_LF = 8'd10;

  // register indexes of the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_WAIT_LIMIT   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_REQUEST_CODE = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ACCEPT_CODE  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DATA_CODE    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SUM_CODE     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_ACK_CODE     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_NACK_CODE    = 3'd6;

  localparam logic [15:0] RST_WAIT_LIMIT   = 16'd1000;
  localparam logic [7:0]  RST_REQUEST_CODE = 8'd1;
  localparam logic [7:0]  RST_ACCEPT_CODE  = 8'd2;
  localparam logic [7:0]  RST_DATA_CODE    = 8'd3;
  localparam logic [7:0]  RST_SUM_CODE     = 8'd4;
  localparam logic [7:0]  RST_ACK_CODE     = 8'd5;
  localparam logic [7:0]  RST_NACK_CODE    = 8'd6;

  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_STATUS = 2'd2
  } res_kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_REFUSED    = 3'd1,
    ST_MISMATCH   = 3'd2,
    ST_UNEXPECTED = 3'd3,
    ST_TIMEOUT    = 3'd4
  } status_t;

  // work handed from the front to the back
  typedef enum logic [1:0] {
    CMD_STATUS       = 2'd0,
    CMD_REPLY        = 2'd1,
    CMD_REPLY_STATUS = 2'd2,
    CMD_DATA         = 2'd3
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] header;
    status_t    status;
  } cmd_t;

  typedef struct packed {
    res_kind_t  kind;
    logic [7:0] value;
    status_t    status;
    logic       last;
  } res_t;

endpackage

FILE: rtl/core/framed_link_receiver.sv
// framed_link_receiver: top level; front, command queue, back, result queue
// depends on flr_pkg, flr_front, flr_back, flr_fifo
// an item's command is queued in the command queue, its results in the result queue
// throughput: one input item a cycle while the command queue has room; the back
// emits one result a cycle while the result queue has room, all of one item first
// reset: synchronous rst clears queues, session, window, sums, ticks; presets regs
module framed_link_receiver #(
  parameter int PAYLOAD_BYTES = flr_pkg::PAYLOAD_BYTES
) (
  input  logic                           clk,
  input  logic                           rst,
  // input queue side
  input  logic                           push,
  output logic                           full,
  input  logic                           op,
  input  logic [7:0]                     rx_byte,
  // configuration writes
  input  logic                           cfg_en,
  input  logic [flr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [flr_pkg::CFG_DATA_W-1:0] cfg_data,
  // result queue side
  output logic                           empty,
  input  logic                           pop,
  output logic [1:0]                     kind,
  output logic [7:0]                     value,
  output logic [2:0]                     status,
  output logic                           last
);

  import flr_pkg::*;

  localparam int PAY_W = PAYLOAD_BYTES * 8;
  localparam int CMD_W = $bits(cmd_t) + PAY_W;

  logic             accept;
  logic             cmd_valid;
  cmd_t             cmd_in;
  logic [PAY_W-1:0] pay_in;
  logic             cq_empty;
  logic [CMD_W-1:0] cq_rdata;
  cmd_t             cmd_out;
  logic [PAY_W-1:0] pay_out;
  logic             cmd_pop;
  logic             res_push;
  logic             res_full;
  res_t             res_in;
  res_t             res_out;

  // an input transfer; full reflects only the command queue
  assign accept = push && !full;

  flr_front #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_en     (cfg_en),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .op         (op),
    .rx_byte    (rx_byte),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd_in),
    .cmd_payload(pay_in)
  );

  // short queue that lets the front keep taking items while the back drains
  flr_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_queue (
    .clk  (clk),
    .rst  (rst),
    .push (cmd_valid),
    .wdata({cmd_in, pay_in}),
    .full (full),
    .pop  (cmd_pop),
    .rdata(cq_rdata),
    .empty(cq_empty)
  );

  assign cmd_out = cmd_t'(cq_rdata[CMD_W-1:PAY_W]);
  assign pay_out = cq_rdata[PAY_W-1:0];

  flr_back #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_avail  (!cq_empty),
    .cmd        (cmd_out),
    .cmd_payload(pay_out),
    .cmd_pop    (cmd_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res_in)
  );

  // output registers; a waiting result never blocks the back while a slot is free
  flr_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_queue (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res_in),
    .full (res_full),
    .pop  (pop),
    .rdata(res_out),
    .empty(empty)
  );

  assign kind   = res_out.kind;
  assign value  = res_out.value;
  assign status = res_out.status;
  assign last   = res_out.last;

endmodule

FILE: rtl/core/flr_fifo.sv
// flr_fifo: small register queue used between front and back and at the output
// depends on nothing; DEPTH must be at least 2
module flr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/flr_front.sv
// flr_front: byte window, frame detection, session state, lane sums, timeout
// and configuration registers; depends on flr_pkg
module flr_front #(
  parameter int PAYLOAD_BYTES = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_en,
  input  logic [flr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [flr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              accept,
  input  logic                              op,
  input  logic [7:0]                        rx_byte,
  output logic                              cmd_valid,
  output flr_pkg::cmd_t                     cmd,
  output logic [PAYLOAD_BYTES*8-1:0]        cmd_payload
);

  import flr_pkg::*;

  localparam int FRAME_LEN = PAYLOAD_BYTES + 3;
  localparam int FW        = $clog2(FRAME_LEN + 1);

  logic [TICK_W-1:0] wait_limit;
  logic [7:0]        request_code;
  logic [7:0]        accept_code;
  logic [7:0]        data_code;
  logic [7:0]        sum_code;
  logic [7:0]        ack_code;
  logic [7:0]        nack_code;

  logic              session_open, session_open_next;
  logic [7:0]        win [FRAME_LEN];
  logic [7:0]        win_next [FRAME_LEN];
  logic [FW-1:0]     fill, fill_next, fill_inc;
  logic [7:0]        sums [PAYLOAD_BYTES];
  logic [7:0]        sums_next [PAYLOAD_BYTES];
  logic [TICK_W-1:0] wait_ticks, wait_ticks_next;
  logic [TICK_W:0]   ticks_inc;
  logic              timeout;
  logic              frame_done;
  logic              match;
  logic [7:0]        header;

  function automatic logic is_end(input logic [7:0] b);
    return (b == BYTE_CR) || (b == BYTE_LF);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_limit   <= RST_WAIT_LIMIT;
      request_code <= RST_REQUEST_CODE;
      accept_code  <= RST_ACCEPT_CODE;
      data_code    <= RST_DATA_CODE;
      sum_code     <= RST_SUM_CODE;
      ack_code     <= RST_ACK_CODE;
      nack_code    <= RST_NACK_CODE;
    end else if (cfg_en) begin
      unique case (cfg_addr)
        REG_WAIT_LIMIT:   wait_limit   <= cfg_data[TICK_W-1:0];
        REG_REQUEST_CODE: request_code <= cfg_data[7:0];
        REG_ACCEPT_CODE:  accept_code  <= cfg_data[7:0];
        REG_DATA_CODE:    data_code    <= cfg_data[7:0];
        REG_SUM_CODE:     sum_code     <= cfg_data[7:0];
        REG_ACK_CODE:     ack_code     <= cfg_data[7:0];
        REG_NACK_CODE:    nack_code    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // shifted window, frame check, timeout compare and payload checksum match
  always_comb begin
    for (int i = 0; i < FRAME_LEN - 1; i++) begin
      win_next[i] = win[i+1];
    end
    win_next[FRAME_LEN-1] = rx_byte;
    fill_inc   = (fill < FW'(FRAME_LEN)) ? fill + 1'b1 : fill;
    frame_done = (fill_inc == FW'(FRAME_LEN)) && is_end(rx_byte) &&
                 is_end(win[FRAME_LEN-1]);
    ticks_inc  = {1'b0, wait_ticks} + 1'b1;
    timeout    = ticks_inc > {1'b0, wait_limit};
    header     = win_next[0];
    match      = 1'b1;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      cmd_payload[i*8 +: 8] = win_next[i+1];
      if (sums[i] != win_next[i+1]) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    session_open_next = session_open;
    fill_next         = fill;
    wait_ticks_next   = wait_ticks;
    sums_next         = sums;
    cmd_valid         = 1'b0;
    cmd.op            = CMD_STATUS;
    cmd.header        = accept_code;
    cmd.status        = ST_OK;
    if (accept) begin
      if (op) begin
        if (timeout) begin
          cmd_valid         = 1'b1;
          cmd.status        = ST_TIMEOUT;
          session_open_next = 1'b0;
          fill_next         = '0;
          wait_ticks_next   = '0;
          for (int i = 0; i < PAYLOAD_BYTES; i++) sums_next[i] = '0;
        end else begin
          wait_ticks_next = ticks_inc[TICK_W-1:0];
        end
      end else begin
        fill_next = fill_inc;
        if (frame_done) begin
          fill_next       = '0;
          wait_ticks_next = '0;
          cmd_valid       = 1'b1;
          if (!session_open) begin
            if (header == request_code) begin
              cmd.op            = CMD_REPLY;
              session_open_next = 1'b1;
              for (int i = 0; i < PAYLOAD_BYTES; i++) sums_next[i] = '0;
            end else begin
              cmd.status = ST_REFUSED;
            end
          end else if (header == data_code) begin
            cmd.op = CMD_DATA;
            for (int i = 0; i < PAYLOAD_BYTES; i++) begin
              sums_next[i] = sums[i] + win_next[i+1];
            end
          end else if (header == sum_code) begin
            cmd.op            = CMD_REPLY_STATUS;
            cmd.header        = match ? ack_code : nack_code;
            cmd.status        = match ? ST_OK : ST_MISMATCH;
            session_open_next = 1'b0;
            for (int i = 0; i < PAYLOAD_BYTES; i++) sums_next[i] = '0;
          end else begin
            cmd.status        = ST_UNEXPECTED;
            session_open_next = 1'b0;
            for (int i = 0; i < PAYLOAD_BYTES; i++) sums_next[i] = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      session_open <= 1'b0;
      fill         <= '0;
      wait_ticks   <= '0;
      for (int i = 0; i < FRAME_LEN; i++) win[i] <= '0;
      for (int i = 0; i < PAYLOAD_BYTES; i++) sums[i] <= '0;
    end else begin
      session_open <= session_open_next;
      fill         <= fill_next;
      wait_ticks   <= wait_ticks_next;
      sums         <= sums_next;
      if (accept && !op) begin
        win <= win_next;
      end
    end
  end

endmodule

FILE: rtl/core/flr_back.sv
// flr_back: expands one queued command into its result items, one per cycle
// while the result queue has room; depends on flr_pkg
module flr_back #(
  parameter int PAYLOAD_BYTES = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_avail,
  input  flr_pkg::cmd_t              cmd,
  input  logic [PAYLOAD_BYTES*8-1:0] cmd_payload,
  output logic                       cmd_pop,
  input  logic                       res_full,
  output logic                       res_push,
  output flr_pkg::res_t              res
);

  import flr_pkg::*;

  localparam int CW  = $clog2(PAYLOAD_BYTES + 4);
  localparam int PIW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

  logic [CW-1:0] idx;
  logic [CW-1:0] last_idx;
  logic [7:0]    pay [PAYLOAD_BYTES];
  logic          fire;

  always_comb begin
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      pay[i] = cmd_payload[i*8 +: 8];
    end
  end

  always_comb begin
    unique case (cmd.op)
      CMD_STATUS:       last_idx = '0;
      CMD_REPLY:        last_idx = CW'(PAYLOAD_BYTES + 2);
      CMD_REPLY_STATUS: last_idx = CW'(PAYLOAD_BYTES + 3);
      CMD_DATA:         last_idx = CW'(PAYLOAD_BYTES - 1);
      default:          last_idx = '0;
    endcase
  end

  assign fire     = cmd_avail && !res_full;
  assign res_push = fire;
  assign cmd_pop  = fire && (idx == last_idx);

  always_comb begin
    res.kind   = KIND_TX;
    res.value  = '0;
    res.status = ST_OK;
    res.last   = (idx == last_idx);
    unique case (cmd.op)
      CMD_STATUS: begin
        res.kind   = KIND_STATUS;
        res.status = cmd.status;
      end
      CMD_DATA: begin
        res.kind  = KIND_DATA;
        res.value = pay[idx[PIW-1:0]];
      end
      default: begin
        // reply frame: header, zero bytes, cr, lf, then status if any
        if (idx == '0) begin
          res.value = cmd.header;
        end else if (idx == CW'(PAYLOAD_BYTES + 1)) begin
          res.value = BYTE_CR;
        end else if (idx == CW'(PAYLOAD_BYTES + 2)) begin
          res.value = BYTE_LF;
        end else if (idx == CW'(PAYLOAD_BYTES + 3)) begin
          res.kind   = KIND_STATUS;
          res.status = cmd.status;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (fire) begin
      idx <= cmd_pop ? '0 : idx + 1'b1;
    end
  end

endmodule

FILE: test/tb.sv
// tb: self-checking bench for framed_link_receiver; drives bytes and ticks, predicts
// every result with a frame-level tracker and compares each popped result in order
// depends on flr_pkg and the framed_link_receiver rtl
`timescale 1ns / 1ps

// tracks session, byte window, lane sums and tick count; queues the results each
// transfer should cause and checks popped results against them
class link_tracker;
  flr_pkg::res_t expected_q[$];
  flr_pkg::res_t batch[$];
  int errors;
  int checked;

  logic [15:0] wait_limit;
  logic [7:0]  request_code;
  logic [7:0]  accept_code;
  logic [7:0]  data_code;
  logic [7:0]  sum_code;
  logic [7:0]  ack_code;
  logic [7:0]  nack_code;

  bit          session_open;
  logic [7:0]  window [flr_pkg::PAYLOAD_BYTES + 3];
  int          fill;
  logic [7:0]  lane_sum [flr_pkg::PAYLOAD_BYTES];
  logic [15:0] ticks;

  function new();
    errors       = 0;
    checked      = 0;
    wait_limit   = flr_pkg::RST_WAIT_LIMIT;
    request_code = flr_pkg::RST_REQUEST_CODE;
    accept_code  = flr_pkg::RST_ACCEPT_CODE;
    data_code    = flr_pkg::RST_DATA_CODE;
    sum_code     = flr_pkg::RST_SUM_CODE;
    ack_code     = flr_pkg::RST_ACK_CODE;
    nack_code    = flr_pkg::RST_NACK_CODE;
    session_open = 1'b0;
    foreach (window[i]) window[i] = 8'h00;
    foreach (lane_sum[i]) lane_sum[i] = 8'h00;
    fill  = 0;
    ticks = 16'd0;
  endfunction

  function void write_reg(logic [flr_pkg::CFG_ADDR_W-1:0] idx,
                          logic [flr_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      flr_pkg::REG_WAIT_LIMIT:   wait_limit   = data[15:0];
      flr_pkg::REG_REQUEST_CODE: request_code = data[7:0];
      flr_pkg::REG_ACCEPT_CODE:  accept_code  = data[7:0];
      flr_pkg::REG_DATA_CODE:    data_code    = data[7:0];
      flr_pkg::REG_SUM_CODE:     sum_code     = data[7:0];
      flr_pkg::REG_ACK_CODE:     ack_code     = data[7:0];
      flr_pkg::REG_NACK_CODE:    nack_code    = data[7:0];
      default: ;
    endcase
  endfunction

  function void emit(flr_pkg::res_kind_t k, logic [7:0] v, flr_pkg::status_t s);
    flr_pkg::res_t r;
    r.kind   = k;
    r.value  = v;
    r.status = s;
    r.last   = 1'b0;
    batch.push_back(r);
  endfunction

  // reply frame: header, zero payload, cr, lf
  function void emit_reply(logic [7:0] hdr);
    emit(flr_pkg::KIND_TX, hdr, flr_pkg::ST_OK);
    for (int i = 0; i < flr_pkg::PAYLOAD_BYTES; i++)
      emit(flr_pkg::KIND_TX, 8'h00, flr_pkg::ST_OK);
    emit(flr_pkg::KIND_TX, flr_pkg::BYTE_CR, flr_pkg::ST_OK);
    emit(flr_pkg::KIND_TX, flr_pkg::BYTE_LF, flr_pkg::ST_OK);
  endfunction

  function void close_session();
    session_open = 1'b0;
    foreach (lane_sum[i]) lane_sum[i] = 8'h00;
  endfunction

  function bit is_end(logic [7:0] b);
    return (b == flr_pkg::BYTE_CR) || (b == flr_pkg::BYTE_LF);
  endfunction

  function void decode_frame();
    logic [7:0] hdr;
    bit         sums_ok;
    hdr = window[0];
    if (!session_open) begin
      if (hdr == request_code) begin
        emit_reply(accept_code);
        session_open = 1'b1;
        foreach (lane_sum[i]) lane_sum[i] = 8'h00;
      end else begin
        emit(flr_pkg::KIND_STATUS, 8'h00, flr_pkg::ST_REFUSED);
      end
    end else if (hdr == data_code) begin
      // data wins over checksum when both codes are equal
      for (int i = 0; i < flr_pkg::PAYLOAD_BYTES; i++) begin
        emit(flr_pkg::KIND_DATA, window[i + 1], flr_pkg::ST_OK);
        lane_sum[i] = lane_sum[i] + window[i + 1];
      end
    end else if (hdr == sum_code) begin
      sums_ok = 1'b1;
      for (int i = 0; i < flr_pkg::PAYLOAD_BYTES; i++)
        if (lane_sum[i] != window[i + 1]) sums_ok = 1'b0;
      emit_reply(sums_ok ? ack_code : nack_code);
      emit(flr_pkg::KIND_STATUS, 8'h00, sums_ok ? flr_pkg::ST_OK : flr_pkg::ST_MISMATCH);
      close_session();
    end else begin
      emit(flr_pkg::KIND_STATUS, 8'h00, flr_pkg::ST_UNEXPECTED);
      close_session();
    end
  endfunction

  // one accepted input transfer: op high is a tick, low is a received byte
  function void note_item(logic is_tick, logic [7:0] b);
    int len;
    len = $size(window);
    batch.delete();
    if (is_tick) begin
      if (({1'b0, ticks} + 17'd1) > {1'b0, wait_limit}) begin
        emit(flr_pkg::KIND_STATUS, 8'h00, flr_pkg::ST_TIMEOUT);
        close_session();
        fill  = 0;
        ticks = 16'd0;
      end else begin
        ticks = ticks + 16'd1;
      end
    end else begin
      for (int i = 0; i < len - 1; i++) window[i] = window[i + 1];
      window[len - 1] = b;
      if (fill < len) fill++;
      if (fill >= len && is_end(window[len - 1]) && is_end(window[len - 2])) begin
        decode_frame();
        fill  = 0;
        ticks = 16'd0;
      end
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) expected_q.push_back(batch[i]);
  endfunction

  task report(string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task check_result(logic [1:0] k, logic [7:0] v, logic [2:0] s, logic l);
    flr_pkg::res_t exp_r;
    checked++;
    if (expected_q.size() == 0) begin
      report($sformatf("result %0d (kind %0d value %0h status %0d) with nothing pending",
                       checked, k, v, s));
      return;
    end
    exp_r = expected_q.pop_front();
    if (k !== exp_r.kind)
      report($sformatf("result %0d kind %0d, want %0d", checked, k, exp_r.kind));
    if (v !== exp_r.value)
      report($sformatf("result %0d value %0h, want %0h", checked, v, exp_r.value));
    if (s !== exp_r.status)
      report($sformatf("result %0d status %0d, want %0d", checked, s, exp_r.status));
    if (l !== exp_r.last)
      report($sformatf("result %0d last %0b, want %0b", checked, l, exp_r.last));
  endtask
endclass

module tb;
  import flr_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 8;      // leave margin for result-free items
  localparam int HOLD_CYCLES   = 64;     // long receiver hold-off, fills both queues
  localparam int LIMIT_CYCLES  = 200000;
  localparam int PHASE_ITEMS   = 14;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;
  // index past the register list, must be ignored by the block
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  logic                  op = 1'b0;
  logic [7:0]            rx_byte = 8'h00;
  logic                  cfg_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [1:0]            kind;
  logic [7:0]            value;
  logic [2:0]            status;
  logic                  last;

  link_tracker tr;
  int          sent_items = 0;
  bit          sender_gaps = 1'b1;
  bit          receiver_stalls = 1'b1;
  bit          hold_req = 1'b0;

  framed_link_receiver i_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .op       (op),
    .rx_byte  (rx_byte),
    .cfg_en   (cfg_en),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .empty    (empty),
    .pop      (pop),
    .kind     (kind),
    .value    (value),
    .status   (status),
    .last     (last)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // hard stop in case a transfer never completes
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Verification failed");
    $finish;
  end

  // monitor: both handshakes are sampled at the rising edge, inputs move on the falling one
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) tr.check_result(kind, value, status, last);
      if (push && !full) tr.note_item(op, rx_byte);
    end
  end

  // receiver: pops every cycle, with short random stalls and one long hold-off on request
  initial begin
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
      pop <= 1'b1;
    end
  end

  // one input transfer; returns at the edge where it was taken
  task send_item(input logic o, input logic [7:0] b);
    int gap;
    gap = (sender_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push    <= 1'b1;
    op      <= o;
    rx_byte <= b;
    do @(posedge clk); while (full);
    sent_items++;
  endtask

  function logic [7:0] end_byte();
    return ($urandom_range(0, 1) == 0) ? BYTE_CR : BYTE_LF;
  endfunction

  // header, payload lanes low byte first, then two random line ends
  task send_frame(input logic [7:0] hdr, input logic [PAYLOAD_BYTES*8-1:0] pay);
    send_item(OP_BYTE, hdr);
    for (int i = 0; i < PAYLOAD_BYTES; i++) send_item(OP_BYTE, pay[i*8 +: 8]);
    send_item(OP_BYTE, end_byte());
    send_item(OP_BYTE, end_byte());
  endtask

  task maybe_ticks();
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) send_item(OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  // stray bytes and ticks, biased toward line ends so odd frames complete
  task send_noise();
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 3) == 0)
        send_item(OP_TICK, 8'($urandom_range(0, 255)));
      else if ($urandom_range(0, 2) == 0)
        send_item(OP_BYTE, end_byte());
      else
        send_item(OP_BYTE, 8'($urandom_range(0, 255)));
    end
  endtask

  // request, up to three payload frames, then mostly a checksum frame, mostly right
  task run_session();
    logic [PAYLOAD_BYTES*8-1:0] lane_acc;
    logic [PAYLOAD_BYTES*8-1:0] pay;
    int                         close_pick;
    int                         lane;
    lane_acc = '0;
    if ($urandom_range(0, 9) == 0) send_frame(8'($urandom_range(0, 255)), $urandom);
    send_frame(tr.request_code, $urandom);
    repeat ($urandom_range(0, 3)) begin
      maybe_ticks();
      pay = $urandom;
      for (int i = 0; i < PAYLOAD_BYTES; i++)
        lane_acc[i*8 +: 8] = lane_acc[i*8 +: 8] + pay[i*8 +: 8];
      send_frame(tr.data_code, pay);
    end
    maybe_ticks();
    close_pick = $urandom_range(0, 9);
    if (close_pick < 6) begin
      send_frame(tr.sum_code, lane_acc);
    end else if (close_pick < 8) begin
      lane = $urandom_range(0, PAYLOAD_BYTES - 1);
      lane_acc[lane*8 +: 8] = lane_acc[lane*8 +: 8] ^ 8'($urandom_range(1, 255));
      send_frame(tr.sum_code, lane_acc);
    end else if (close_pick < 9) begin
      send_frame(8'($urandom_range(0, 255)), $urandom);
    end
    // otherwise the session stays open for the next request to hit
  endtask

  task run_traffic(input int n_items);
    int start;
    int pick;
    start = sent_items;
    while (sent_items - start < n_items) begin
      pick = $urandom_range(0, 19);
      if (pick < 14)      run_session();
      else if (pick < 17) send_noise();
      else                send_frame(8'($urandom_range(0, 255)), $urandom);
    end
  endtask

  // stop sending, let every pending result drain, then let the block go quiet
  task wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (tr.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task cfg_write(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_en   <= 1'b1;
    cfg_addr <= a;
    cfg_data <= d;
    @(posedge clk);
    tr.write_reg(a, d);
  endtask

  // byte registers get random upper bits, which must be dropped
  task program_regs(input logic [15:0] wl, input logic [7:0] req, input logic [7:0] acc,
                    input logic [7:0] dat, input logic [7:0] sm, input logic [7:0] ak,
                    input logic [7:0] nk);
    cfg_write(REG_WAIT_LIMIT, wl);
    cfg_write(REG_REQUEST_CODE, {8'($urandom), req});
    cfg_write(REG_ACCEPT_CODE, {8'($urandom), acc});
    cfg_write(REG_DATA_CODE, {8'($urandom), dat});
    cfg_write(REG_SUM_CODE, {8'($urandom), sm});
    cfg_write(REG_ACK_CODE, {8'($urandom), ak});
    cfg_write(REG_NACK_CODE, {8'($urandom), nk});
    cfg_write(REG_UNUSED, 16'($urandom));
    @(negedge clk);
    cfg_en <= 1'b0;
  endtask

  initial begin
    logic [7:0] shared_code;
    tr = new();
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // directed pass on reset values: tick in time, accept, all-ones payload, good checksum
    send_item(OP_TICK, 8'hFF);
    send_frame(tr.request_code, '0);
    send_frame(tr.data_code, '1);
    send_frame(tr.sum_code, '1);
    wait_idle();

    // no timeout possible, extreme codes; receiver holds off while we keep pushing
    program_regs(16'hFFFF, 8'h00, 8'hFF, 8'($urandom), 8'($urandom), 8'h00, 8'hFF);
    hold_req = 1'b1;
    run_traffic(PHASE_ITEMS);
    wait_idle();

    // every tick times out
    program_regs(16'h0000, 8'hFF, 8'h00, 8'h00, 8'($urandom), 8'hFF, 8'h00);
    run_traffic(PHASE_ITEMS);
    wait_idle();

    // payload and checksum share a header, short tick budget
    shared_code = 8'($urandom);
    program_regs(16'($urandom_range(2, 8)), 8'($urandom), 8'($urandom), shared_code,
                 shared_code, 8'($urandom), 8'($urandom));
    run_traffic(PHASE_ITEMS);
    wait_idle();

    // closing stretch runs flat out on both sides
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    program_regs(16'($urandom_range(0, 40)), 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom), 8'($urandom), 8'($urandom));
    run_traffic(PHASE_ITEMS);
    wait_idle();

    if (tr.errors == 0 && tr.expected_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
